// File: design/xmcrc_pkg.sv
// Package for the Xmodem-CRC packet receiver: sizes, codes, item structs
// and the bytewise CRC-16 function. No dependencies.
`default_nettype none

package xmcrc_pkg;

   // Page and packet geometry
   localparam int PAGE_BYTES        = 1024;
   localparam int PACKET_DATA_BYTES = 128;
   localparam int PKTS_PER_PAGE     = PAGE_BYTES / PACKET_DATA_BYTES;
   localparam int PAGE_BITS         = $clog2(PAGE_BYTES);
   localparam int DATA_BITS         = $clog2(PACKET_DATA_BYTES);
   localparam int SLOT_BITS         = $clog2(PKTS_PER_PAGE);

   // Field widths
   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 10;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 11;
   localparam int COUNT_W  = 16;

   // Byte positions within one packet
   localparam logic [7:0] POS_DATA_FIRST = 8'd3;
   localparam logic [7:0] POS_DATA_LAST  = 8'd130;
   localparam logic [7:0] POS_CRC_HI     = 8'd131;
   localparam logic [7:0] POS_LAST       = 8'd132;

   // CRC-16/XMODEM
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BYTE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STATUS = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_END    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd5;

   // Reply codes
   localparam logic [1:0] RPL_NONE = 2'd0;
   localparam logic [1:0] RPL_ACK  = 2'd1;
   localparam logic [1:0] RPL_NAK  = 2'd2;
   localparam logic [1:0] RPL_C    = 2'd3;

   // Flash request codes
   localparam logic [1:0] FRQ_NONE  = 2'd0;
   localparam logic [1:0] FRQ_ERASE = 2'd1;
   localparam logic [1:0] FRQ_WRITE = 2'd2;

   // Register indexes
   localparam logic CSR_PARTITION_BASE = 1'b0;
   localparam logic CSR_POLL_INTERVAL  = 1'b1;

   localparam logic [ADDR_W-1:0] PARTITION_BASE_RESET = 32'h0800_0000;
   localparam logic [7:0]        POLL_INTERVAL_RESET  = 8'd100;

   // Pending flash operation
   typedef enum logic [1:0] {
      W_IDLE  = 2'd0,
      W_ERASE = 2'd1,
      W_WRITE = 2'd2,
      W_END   = 2'd3
   } wait_type;

   // Result fields except the buffer byte
   typedef struct packed {
      logic [1:0]         reply_code;
      logic [1:0]         flash_request;
      logic [ADDR_W-1:0]  write_address;
      logic [LEN_W-1:0]   write_length;
      logic [COUNT_W-1:0] packets_accepted;
   } result_type;

   // Page buffer access for one item
   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [PAGE_BITS-1:0] addr;
      logic [7:0]           wdata;
   } mem_req_type;

   // One byte through CRC-16, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: design/xmcrc_page_ram.sv
// Page buffer: single-port synchronous RAM, one byte wide, read data
// registered. Depends on xmcrc_pkg for its depth.
`default_nettype none

module xmcrc_page_ram (
   input  wire logic                          clock,
   input  wire xmcrc_pkg::mem_req_type        mem_req,
   output logic [7:0]                         rd_data
);

   logic [7:0] mem [xmcrc_pkg::PAGE_BYTES];
   logic [7:0] rd_data_ff;

   // Write or read, one access per cycle
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/xmcrc_ctrl.sv
// Receiver control: packet position, CRC, flash wait, tick timer, counter
// and configuration registers; drives page buffer accesses. Uses xmcrc_pkg.
`default_nettype none

module xmcrc_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire logic [xmcrc_pkg::ACTION_W-1:0]    action,
   input  wire logic [7:0]                        rx_byte,
   input  wire logic                              op_ok,
   input  wire logic [xmcrc_pkg::INDEX_W-1:0]     buffer_index,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [xmcrc_pkg::ADDR_W-1:0]      csr_wdata,
   output xmcrc_pkg::result_type                  result,
   output logic                                   rd_valid,
   output xmcrc_pkg::mem_req_type                 mem_req
);

   localparam int CALC_W = xmcrc_pkg::ADDR_W;

   logic [xmcrc_pkg::ADDR_W-1:0]  base_ff;
   logic [7:0]                    poll_ff;
   logic [xmcrc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                    pos_ff, pos_in;
   logic [15:0]                   crc_ff, crc_in;
   logic [7:0]                    crc_hi_ff, crc_hi_in;
   xmcrc_pkg::wait_type           wait_ff, wait_in;
   logic [7:0]                    timer_ff, timer_in;

   logic [xmcrc_pkg::COUNT_W-1:0] count_inc;
   logic [15:0]                   crc_base;
   logic [7:0]                    data_off;
   logic [CALC_W-1:0]             page_full_addr;
   logic [CALC_W-1:0]             page_part_addr;
   logic [CALC_W-1:0]             part_len;
   logic [xmcrc_pkg::SLOT_BITS-1:0] part;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= xmcrc_pkg::PARTITION_BASE_RESET;
         poll_ff <= xmcrc_pkg::POLL_INTERVAL_RESET;
      end else if (csr_we) begin
         if (csr_index == xmcrc_pkg::CSR_PARTITION_BASE) begin
            base_ff <= csr_wdata;
         end else begin
            poll_ff <= csr_wdata[7:0];
         end
      end
   end

   // Shared address arithmetic
   always_comb begin
      count_inc      = count_ff + 1'b1;
      crc_base       = (pos_ff == 8'd0) ? xmcrc_pkg::CRC_INIT : crc_ff;
      data_off       = pos_ff - xmcrc_pkg::POS_DATA_FIRST;
      // full page just closed: page index (count+1)/ppp - 1, wraps modulo 2^32
      page_full_addr = base_ff
                     + (CALC_W'(count_inc >> xmcrc_pkg::SLOT_BITS) << xmcrc_pkg::PAGE_BITS)
                     - CALC_W'(xmcrc_pkg::PAGE_BYTES);
      page_part_addr = base_ff
                     + (CALC_W'(count_ff >> xmcrc_pkg::SLOT_BITS) << xmcrc_pkg::PAGE_BITS);
      part           = count_ff[xmcrc_pkg::SLOT_BITS-1:0];
      part_len       = CALC_W'(part) << xmcrc_pkg::DATA_BITS;
   end

   // Item decode and next state
   always_comb begin
      logic accept;
      accept    = 1'b0;
      count_in  = count_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_hi_in = crc_hi_ff;
      wait_in   = wait_ff;
      timer_in  = timer_ff;
      result    = '0;
      rd_valid  = 1'b0;
      mem_req   = '0;
      mem_req.wdata = rx_byte;

      unique case (action)
         xmcrc_pkg::ACT_START: begin
            count_in = '0;
            timer_in = '0;
            pos_in   = '0;
            crc_in   = xmcrc_pkg::CRC_INIT;
            wait_in  = xmcrc_pkg::W_IDLE;
         end
         xmcrc_pkg::ACT_TICK: begin
            if (timer_ff >= poll_ff) begin
               result.reply_code = xmcrc_pkg::RPL_C;
               timer_in = 8'd1;
            end else begin
               timer_in = timer_ff + 8'd1;
            end
         end
         xmcrc_pkg::ACT_BYTE: begin
            if (wait_ff == xmcrc_pkg::W_IDLE) begin
               crc_in = crc_base;
               if (pos_ff >= xmcrc_pkg::POS_DATA_FIRST && pos_ff <= xmcrc_pkg::POS_DATA_LAST) begin
                  // stage into the slot of this packet
                  mem_req.we   = 1'b1;
                  mem_req.addr = xmcrc_pkg::PAGE_BITS'({count_ff[xmcrc_pkg::SLOT_BITS-1:0],
                                    data_off[xmcrc_pkg::DATA_BITS-1:0]});
                  crc_in = xmcrc_pkg::crc_byte(crc_base, rx_byte);
               end else if (pos_ff == xmcrc_pkg::POS_CRC_HI) begin
                  crc_hi_in = rx_byte;
               end else if (pos_ff == xmcrc_pkg::POS_LAST) begin
                  if ({crc_hi_ff, rx_byte} == crc_base) begin
                     if (count_ff == '0) begin
                        result.flash_request = xmcrc_pkg::FRQ_ERASE;
                        wait_in = xmcrc_pkg::W_ERASE;
                     end else begin
                        accept = 1'b1;
                     end
                  end else begin
                     result.reply_code = xmcrc_pkg::RPL_NAK;
                  end
               end
               if (pos_ff >= xmcrc_pkg::POS_LAST) begin
                  pos_in = '0;
                  crc_in = xmcrc_pkg::CRC_INIT;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end
         xmcrc_pkg::ACT_STATUS: begin
            unique case (wait_ff)
               xmcrc_pkg::W_ERASE: begin
                  wait_in = xmcrc_pkg::W_IDLE;
                  if (op_ok) begin
                     accept = 1'b1;
                  end else begin
                     result.reply_code = xmcrc_pkg::RPL_NAK;
                  end
               end
               xmcrc_pkg::W_WRITE: begin
                  wait_in = xmcrc_pkg::W_IDLE;
                  result.reply_code = op_ok ? xmcrc_pkg::RPL_ACK : xmcrc_pkg::RPL_NAK;
               end
               xmcrc_pkg::W_END: begin
                  wait_in = xmcrc_pkg::W_IDLE;
               end
               default: begin
               end
            endcase
         end
         xmcrc_pkg::ACT_END: begin
            if (wait_ff == xmcrc_pkg::W_IDLE) begin
               result.reply_code = xmcrc_pkg::RPL_ACK;
               if (part != '0) begin
                  result.flash_request = xmcrc_pkg::FRQ_WRITE;
                  result.write_address = page_part_addr;
                  result.write_length  = part_len[xmcrc_pkg::LEN_W-1:0];
                  wait_in = xmcrc_pkg::W_END;
               end
            end
         end
         xmcrc_pkg::ACT_READ: begin
            mem_req.re   = 1'b1;
            mem_req.addr = xmcrc_pkg::PAGE_BITS'(buffer_index);
            rd_valid     = (CALC_W'(buffer_index) < CALC_W'(xmcrc_pkg::PAGE_BYTES));
         end
         default: begin
         end
      endcase

      // good packet: raise count; write out the page once it is full, else ACK
      if (accept) begin
         count_in = count_inc;
         if (count_inc[xmcrc_pkg::SLOT_BITS-1:0] == '0) begin
            result.flash_request = xmcrc_pkg::FRQ_WRITE;
            result.write_address = page_full_addr;
            result.write_length  = xmcrc_pkg::LEN_W'(xmcrc_pkg::PAGE_BYTES);
            wait_in = xmcrc_pkg::W_WRITE;
         end else begin
            result.reply_code = xmcrc_pkg::RPL_ACK;
         end
      end

      result.packets_accepted = count_in;
      if (!fire) begin
         mem_req.we = 1'b0;
         mem_req.re = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pos_ff    <= '0;
         crc_ff    <= '0;
         crc_hi_ff <= '0;
         wait_ff   <= xmcrc_pkg::W_IDLE;
         timer_ff  <= '0;
      end else if (fire) begin
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_hi_ff <= crc_hi_in;
         wait_ff   <= wait_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

`default_nettype wire

// File: design/xmcrc_packet_receiver_core_dummy_never.sv
// Result pipeline for the Xmodem-CRC receiver: holds one item while the
// page buffer read completes. Uses xmcrc_pkg.
`default_nettype none

module xmcrc_rsp_pipe (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire xmcrc_pkg::result_type  result,
   input  wire logic                   rd_valid,
   input  wire logic [7:0]             rd_data,
   input  wire logic                   rsp_stall,
   output logic                        s1_busy,
   output logic                        rsp_valid,
   output xmcrc_pkg::result_type       rsp_result,
   output logic [7:0]                  rsp_read_data
);

   logic                  s1_valid_ff, s1_valid_in;
   xmcrc_pkg::result_type s1_res_ff;
   logic                  s1_rd_ff;
   logic                  out_valid_ff, out_valid_in;
   xmcrc_pkg::result_type out_res_ff;
   logic [7:0]            out_rd_ff;
   logic                  s1_go;

   // stage 1 moves on when the output register is free or being taken
   always_comb begin
      s1_go        = !out_valid_ff || !rsp_stall;
      s1_busy      = s1_valid_ff && !s1_go;
      s1_valid_in  = fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_go ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (fire) begin
         s1_res_ff <= result;
         s1_rd_ff  <= rd_valid;
      end
      if (s1_go && s1_valid_ff) begin
         out_res_ff <= s1_res_ff;
         out_rd_ff  <= s1_rd_ff ? rd_data : 8'd0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = out_res_ff;
   assign rsp_read_data = out_rd_ff;

endmodule

`default_nettype wire

// File: design/xmodem_crc_packet_receiver_core.sv
// Top level of the Xmodem-CRC packet receiver: control, page buffer RAM and
// result pipeline. Uses xmcrc_pkg, xmcrc_ctrl, xmcrc_page_ram, xmcrc_rsp_pipe.
//
//   channel | ports                         | direction
//   req     | req_valid / req_stall, fields | in, one item per action
//   rsp     | rsp_valid / rsp_stall, fields | out, one item per req item
//   csr     | csr_we, csr_index, csr_wdata  | in, write only
//
// One item per cycle while req_stall is low; each result reaches rsp through
// stage 1, loaded with the page buffer read at acceptance, and then the output
// register, which rsp_stall can hold back.
// Control state updates at acceptance, so items follow back to back; the
// single RAM port carries either the staging write or the read of one item.
// Synchronous reset clears control state; the page buffer is not cleared.
// req_stall rises only when both result stages are full and rsp is stalled.
`default_nettype none

module xmodem_crc_packet_receiver_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [xmcrc_pkg::ACTION_W-1:0]    req_action,
   input  wire logic [7:0]                        req_rx_byte,
   input  wire logic                              req_op_ok,
   input  wire logic [xmcrc_pkg::INDEX_W-1:0]     req_buffer_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_reply_code,
   output logic [1:0]                             rsp_flash_request,
   output logic [xmcrc_pkg::ADDR_W-1:0]           rsp_write_address,
   output logic [xmcrc_pkg::LEN_W-1:0]            rsp_write_length,
   output logic [7:0]                             rsp_read_data,
   output logic [xmcrc_pkg::COUNT_W-1:0]          rsp_packets_accepted,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [xmcrc_pkg::ADDR_W-1:0]      csr_wdata
);

   logic                   fire;
   logic                   s1_busy;
   logic                   rd_valid;
   logic [7:0]             rd_data;
   xmcrc_pkg::result_type  result;
   xmcrc_pkg::result_type  rsp_result;
   xmcrc_pkg::mem_req_type mem_req;

   assign req_stall = s1_busy;
   assign fire      = req_valid && !s1_busy;

   xmcrc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .action       (req_action),
      .rx_byte      (req_rx_byte),
      .op_ok        (req_op_ok),
      .buffer_index (req_buffer_index),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result       (result),
      .rd_valid     (rd_valid),
      .mem_req      (mem_req)
   );

   xmcrc_page_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   xmcrc_rsp_pipe u_pipe (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .result        (result),
      .rd_valid      (rd_valid),
      .rd_data       (rd_data),
      .rsp_stall     (rsp_stall),
      .s1_busy       (s1_busy),
      .rsp_valid     (rsp_valid),
      .rsp_result    (rsp_result),
      .rsp_read_data (rsp_read_data)
   );

   assign rsp_reply_code       = rsp_result.reply_code;
   assign rsp_flash_request    = rsp_result.flash_request;
   assign rsp_write_address    = rsp_result.write_address;
   assign rsp_write_length     = rsp_result.write_length;
   assign rsp_packets_accepted = rsp_result.packets_accepted;

endmodule

`default_nettype wire

// File: tb/sv/xmodem_crc_packet_receiver_core_tb.sv
// Self-checking testbench for xmodem_crc_packet_receiver_core: packet, tick,
// flash status and buffer read items against an in-bench receiver predictor.
// Depends on xmcrc_pkg and the core; needs nothing else.

module xmodem_crc_packet_receiver_core_tb;

   import xmcrc_pkg::*;

   // Spare action codes the core must ignore
   localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;
   localparam logic [7:0]          SOH        = 8'h01;
   localparam int                  HOLD_CYCLES = 60;
   localparam int                  CYCLE_LIMIT = 250_000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [7:0]          rx_byte;
      logic                op_ok;
      logic [INDEX_W-1:0]  index;
   } rx_item_type;

   typedef struct packed {
      logic [1:0]         reply;
      logic [1:0]         flash_req;
      logic [ADDR_W-1:0]  addr;
      logic [LEN_W-1:0]   len;
      logic [7:0]         rdata;
      logic [COUNT_W-1:0] count;
   } receiver_reply_type;

   // Clock, reset and core inputs, all known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [ACTION_W-1:0] req_action = '0;
   logic [7:0]          req_rx_byte = '0;
   logic                req_op_ok = 1'b0;
   logic [INDEX_W-1:0]  req_buffer_index = '0;
   logic                rsp_stall = 1'b0;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [ADDR_W-1:0]   csr_wdata = '0;

   logic                req_stall;
   logic                rsp_valid;
   logic [1:0]          rsp_reply_code;
   logic [1:0]          rsp_flash_request;
   logic [ADDR_W-1:0]   rsp_write_address;
   logic [LEN_W-1:0]    rsp_write_length;
   logic [7:0]          rsp_read_data;
   logic [COUNT_W-1:0]  rsp_packets_accepted;

   // Item and reply queues
   rx_item_type        pending_items[$];
   receiver_reply_type expected_replies[$];
   int                 generated = 0;
   int                 mismatches = 0;
   int                 replies_seen = 0;
   int                 cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;

   // Predictor state
   logic [ADDR_W-1:0]  pr_base;
   logic [7:0]         pr_poll;
   logic [COUNT_W-1:0] pr_count;
   logic [7:0]         pr_pos;
   logic [15:0]        pr_crc;
   logic [7:0]         pr_crc_hi;
   wait_type           pr_wait;
   logic [7:0]         pr_timer;
   logic [7:0]         pr_page [PAGE_BYTES];
   int                 slot_fill [PKTS_PER_PAGE];

   xmodem_crc_packet_receiver_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_rx_byte          (req_rx_byte),
      .req_op_ok            (req_op_ok),
      .req_buffer_index     (req_buffer_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_reply_code       (rsp_reply_code),
      .rsp_flash_request    (rsp_flash_request),
      .rsp_write_address    (rsp_write_address),
      .rsp_write_length     (rsp_write_length),
      .rsp_read_data        (rsp_read_data),
      .rsp_packets_accepted (rsp_packets_accepted),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Random field values
   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   function automatic logic any_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom);
   endfunction

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      repeat (8) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // Good packet: count up, ask for a page write when a page has filled
   task automatic count_packet(inout receiver_reply_type r);
      pr_count = pr_count + 16'd1;
      if (int'(pr_count) % PKTS_PER_PAGE == 0) begin
         r.flash_req = FRQ_WRITE;
         r.addr      = pr_base + ADDR_W'((int'(pr_count) / PKTS_PER_PAGE - 1) * PAGE_BYTES);
         r.len       = LEN_W'(PAGE_BYTES);
         pr_wait     = W_WRITE;
      end else begin
         r.reply = RPL_ACK;
      end
   endtask

   // Receiver behavior for one item
   task automatic advance_receiver(input rx_item_type it, output receiver_reply_type r);
      int          slot;
      int          offs;
      int          part;
      logic [15:0] got;
      r = '0;
      case (it.action)
         ACT_START: begin
            pr_count = '0;
            pr_timer = '0;
            pr_pos   = '0;
            pr_crc   = '0;
            pr_wait  = W_IDLE;
         end
         ACT_TICK: begin
            if (pr_timer >= pr_poll) begin
               r.reply  = RPL_C;
               pr_timer = '0;
            end
            pr_timer = pr_timer + 8'd1;
         end
         ACT_BYTE: begin
            if (pr_wait == W_IDLE) begin
               if (pr_pos == 8'd0) pr_crc = '0;
               if (pr_pos >= POS_DATA_FIRST && pr_pos <= POS_DATA_LAST) begin
                  slot = int'(pr_count) % PKTS_PER_PAGE;
                  offs = int'(pr_pos) - int'(POS_DATA_FIRST);
                  pr_page[slot * PACKET_DATA_BYTES + offs] = it.rx_byte;
                  if (slot_fill[slot] < offs + 1) slot_fill[slot] = offs + 1;
                  pr_crc = crc16_step(pr_crc, it.rx_byte);
               end else if (pr_pos == POS_CRC_HI) begin
                  pr_crc_hi = it.rx_byte;
               end else if (pr_pos == POS_LAST) begin
                  got = {pr_crc_hi, it.rx_byte};
                  if (got != pr_crc) begin
                     r.reply = RPL_NAK;
                  end else if (pr_count == '0) begin
                     r.flash_req = FRQ_ERASE;
                     pr_wait     = W_ERASE;
                  end else begin
                     count_packet(r);
                  end
               end
               if (pr_pos >= POS_LAST) begin
                  pr_pos = '0;
                  pr_crc = '0;
               end else begin
                  pr_pos = pr_pos + 8'd1;
               end
            end
         end
         ACT_STATUS: begin
            case (pr_wait)
               W_ERASE: begin
                  pr_wait = W_IDLE;
                  if (it.op_ok) count_packet(r);
                  else r.reply = RPL_NAK;
               end
               W_WRITE: begin
                  pr_wait = W_IDLE;
                  r.reply = it.op_ok ? RPL_ACK : RPL_NAK;
               end
               W_END: pr_wait = W_IDLE;
               default: ;
            endcase
         end
         ACT_END: begin
            if (pr_wait == W_IDLE) begin
               r.reply = RPL_ACK;
               part = int'(pr_count) % PKTS_PER_PAGE;
               if (part != 0) begin
                  r.flash_req = FRQ_WRITE;
                  r.addr      = pr_base +
                                ADDR_W'((int'(pr_count) / PKTS_PER_PAGE) * PAGE_BYTES);
                  r.len       = LEN_W'(part * PACKET_DATA_BYTES);
                  pr_wait     = W_END;
               end
            end
         end
         ACT_READ: begin
            if (int'(it.index) < PAGE_BYTES) r.rdata = pr_page[it.index];
         end
         default: ;
      endcase
      r.count = pr_count;
   endtask

   // Predict one item and queue it with its reply
   task automatic queue_item(input logic [ACTION_W-1:0] act, input logic [7:0] rx,
                             input logic ok, input logic [INDEX_W-1:0] idx);
      rx_item_type        it;
      receiver_reply_type r;
      it = '{action: act, rx_byte: rx, op_ok: ok, index: idx};
      advance_receiver(it, r);
      pending_items.push_back(it);
      expected_replies.push_back(r);
      generated++;
   endtask

   task automatic queue_plain(input logic [ACTION_W-1:0] act);
      queue_item(act, any_byte(), any_bit(), any_index());
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_item(ACT_BYTE, b, any_bit(), any_index());
   endtask

   // Reads go only to staged bytes; a tick stands in while nothing is staged
   task automatic queue_read();
      int filled[$];
      int s;
      for (int i = 0; i < PKTS_PER_PAGE; i++) begin
         if (slot_fill[i] > 0) filled.push_back(i);
      end
      if (filled.size() == 0) begin
         queue_plain(ACT_TICK);
      end else begin
         s = filled[$urandom_range(filled.size() - 1)];
         queue_item(ACT_READ, any_byte(), any_bit(),
                    INDEX_W'(s * PACKET_DATA_BYTES + $urandom_range(slot_fill[s] - 1)));
      end
   endtask

   // Side items; inside a packet only those that leave the framing alone
   task automatic queue_noise(input bit mid_packet);
      case ($urandom_range(mid_packet ? 3 : 5))
         0: queue_plain(ACT_TICK);
         1: queue_read();
         2: queue_plain($urandom_range(1) ? ACT_RSVD_A : ACT_RSVD_B);
         3: queue_plain(ACT_STATUS);
         4: queue_plain(ACT_BYTE);
         default: queue_plain(ACT_END);
      endcase
   endtask

   // One 133-byte packet, after settling any flash wait and realigning
   task automatic queue_packet(input int bad_pct, input int fail_pct, input int noise_pct);
      int          fill_kind;
      logic [7:0]  blk;
      logic [7:0]  b;
      logic [15:0] sent;
      while (pr_wait != W_IDLE || pr_pos != 8'd0) begin
         if (pr_wait == W_IDLE) begin
            queue_plain(ACT_BYTE);
         end else begin
            case ($urandom_range(9))
               0, 1: queue_plain(ACT_BYTE);  // dropped while waiting
               2: queue_plain(ACT_END);      // dropped too
               default: queue_item(ACT_STATUS, any_byte(),
                                   $urandom_range(99) >= fail_pct, any_index());
            endcase
         end
      end
      blk = pr_count[7:0] + 8'd1;
      if ($urandom_range(4) == 0) blk = any_byte();
      queue_byte(SOH);
      queue_byte(blk);
      queue_byte(~blk);
      fill_kind = $urandom_range(3);
      for (int i = 0; i < PACKET_DATA_BYTES; i++) begin
         case (fill_kind)
            0: b = any_byte();
            1: b = 8'h00;
            2: b = 8'hFF;
            default: b = 8'(i * 3) + blk;
         endcase
         queue_byte(b);
         if ($urandom_range(99) < noise_pct / 4) queue_noise(1'b1);
      end
      sent = pr_crc;
      if ($urandom_range(99) < bad_pct) sent ^= 16'h1 << $urandom_range(15);
      queue_byte(sent[15:8]);
      queue_byte(sent[7:0]);
   endtask

   // Random traffic, mostly whole packets
   task automatic run_random(input int budget, input int bad_pct, input int fail_pct,
                             input int start_pct, input int end_pct, input int noise_pct);
      int target;
      int pick;
      target = generated + budget;
      while (generated < target) begin
         pick = $urandom_range(99);
         if (pick < start_pct) begin
            queue_plain(ACT_START);
         end else if (pick < start_pct + end_pct) begin
            queue_plain(ACT_END);
         end else if (pick < start_pct + end_pct + noise_pct) begin
            repeat ($urandom_range(1, 6)) queue_noise(1'b0);
         end else begin
            queue_packet(bad_pct, fail_pct, noise_pct);
         end
      end
   endtask

   task automatic write_csr(input logic idx, input logic [ADDR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_PARTITION_BASE) pr_base = val;
      else pr_poll = val[7:0];
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Reconfigure between phases with the core idle
   task automatic start_phase(input logic [ADDR_W-1:0] base, input logic [7:0] poll,
                              input int sender_idle, input int receiver_idle);
      wait_drained();
      write_csr(CSR_PARTITION_BASE, base);
      write_csr(CSR_POLL_INTERVAL, {24'd0, poll});
      send_idle_pct <= sender_idle;
      recv_idle_pct <= receiver_idle;
      @(negedge clock);
   endtask

   // Driver: next item once the current one is taken
   always @(posedge clock) begin
      rx_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_valid        <= 1'b1;
            req_action       <= it.action;
            req_rx_byte      <= it.rx_byte;
            req_op_ok        <= it.op_ok;
            req_buffer_index <= it.index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall, with one long hold-off to back the core up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && replies_seen >= 40) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // Monitor: compare each taken reply with the oldest prediction
   always @(posedge clock) begin
      receiver_reply_type seen;
      receiver_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen <= replies_seen + 1;
         seen = '{reply: rsp_reply_code, flash_req: rsp_flash_request,
                  addr: rsp_write_address, len: rsp_write_length,
                  rdata: rsp_read_data, count: rsp_packets_accepted};
         if (expected_replies.size() == 0) begin
            if (mismatches < 10) $display("reply with nothing expected: %p", seen);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (seen.reply !== want.reply || seen.flash_req !== want.flash_req ||
                seen.addr !== want.addr || seen.len !== want.len ||
                seen.rdata !== want.rdata || seen.count !== want.count) begin
               if (mismatches < 10) begin
                  $display("reply %0d mismatch (exp/act): code %0d/%0d req %0d/%0d",
                           replies_seen, want.reply, seen.reply, want.flash_req,
                           seen.flash_req);
                  $display("   addr %h/%h len %0d/%0d data %h/%h count %0d/%0d",
                           want.addr, seen.addr, want.len, seen.len, want.rdata,
                           seen.rdata, want.count, seen.count);
               end
               mismatches++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      pr_base   = PARTITION_BASE_RESET;
      pr_poll   = POLL_INTERVAL_RESET;
      pr_count  = '0;
      pr_pos    = '0;
      pr_crc    = CRC_INIT;
      pr_crc_hi = '0;
      pr_wait   = W_IDLE;
      pr_timer  = '0;
      for (int i = 0; i < PKTS_PER_PAGE; i++) slot_fill[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      start_phase(32'h0800_0000, 8'd1, 29, 45);
      // directed: spare codes, status and end while idle, tick timing, edge bytes
      queue_item(ACT_RSVD_A, 8'hFF, 1'b1, '1);
      queue_item(ACT_RSVD_B, 8'h00, 1'b0, '0);
      queue_item(ACT_STATUS, 8'h00, 1'b1, '0);
      queue_item(ACT_STATUS, 8'hFF, 1'b0, '1);
      queue_plain(ACT_END);
      queue_plain(ACT_TICK);
      queue_plain(ACT_TICK);
      queue_plain(ACT_TICK);
      queue_plain(ACT_START);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_plain(ACT_START);
      run_random(100, 15, 20, 4, 6, 10);

      // slowest poll rate; a long tick run reaches it
      start_phase(32'h0000_0000, 8'd255, 29, 45);
      repeat (260) queue_plain(ACT_TICK);

      // packets and end-of-transfer writes near the top of the address space
      start_phase(32'hFFFF_FC00, 8'd3, 45, 29);
      queue_plain(ACT_START);
      run_random(100, 15, 20, 2, 8, 12);

      start_phase(ADDR_W'($urandom), 8'($urandom_range(1, 255)), 0, 0);
      run_random(60, 15, 20, 4, 6, 10);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
